// ===== design/wtk_pkg.sv =====
// shared constants and types for the windowed top-k dot product search
package wtk_pkg;

	localparam int MAX_DIM_DEF      = 64;
	localparam int CORPUS_DEPTH_DEF = 4096;
	localparam int TOP_MAX_DEF      = 16;

	localparam logic [31:0] MAX_ID_DIFF_RST   = 32'd300000;
	localparam logic [4:0]  TOP_COUNT_RST     = 5'd10;
	localparam logic [6:0]  VECTOR_LENGTH_RST = 7'd64;

	localparam logic [1:0] REG_MAX_ID_DIFF   = 2'd0;
	localparam logic [1:0] REG_TOP_COUNT     = 2'd1;
	localparam logic [1:0] REG_VECTOR_LENGTH = 2'd2;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_QUERY = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam int SCORE_W = 40;
	localparam logic signed [63:0] SCORE_MAX = 64'sd549755813887;
	localparam logic signed [63:0] SCORE_MIN = -64'sd549755813888;

	typedef struct packed {
		logic clear;
		logic vld;
		logic last;
	} mac_ctl_t;

endpackage

// ===== design/wtk_ram.sv =====
// generic single write, single read ram with registered read data
module wtk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/wtk_mac.sv =====
// shared multiply-accumulate unit with a registered product stage
module wtk_mac #(
	parameter int ACC_W = 41
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wtk_pkg::mac_ctl_t       ctl,
	input  logic signed [15:0]      a,
	input  logic signed [15:0]      b,
	output logic signed [ACC_W-1:0] acc,
	output logic                    done
);

	logic signed [31:0]      prod_s2;
	logic                    vld_s2;
	logic                    last_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic                    done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s2  <= ctl.vld && !ctl.clear;
			last_s2 <= ctl.vld && ctl.last && !ctl.clear;
			done_q  <= vld_s2 && last_s2 && !ctl.clear;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// ===== design/wtk_topk.sv =====
// best-first list of scores and ids, one sorted insert per cycle
module wtk_topk #(
	parameter int TOP_MAX = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               ins,
	input  logic signed [wtk_pkg::SCORE_W-1:0] ins_score,
	input  logic [31:0]                        ins_id,
	input  logic [$clog2(TOP_MAX+1)-1:0]       k,
	input  logic [$clog2(TOP_MAX+1)-1:0]       rd_idx,
	output logic [$clog2(TOP_MAX+1)-1:0]       kept,
	output logic signed [wtk_pkg::SCORE_W-1:0] rd_score,
	output logic [31:0]                        rd_id
);

	localparam int TOP_W = $clog2(TOP_MAX+1);
	localparam int IX_W  = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;

	logic signed [wtk_pkg::SCORE_W-1:0] score_q [TOP_MAX];
	logic [31:0]                        id_q [TOP_MAX];
	logic [TOP_W-1:0]                   kept_q;
	logic [TOP_W-1:0]                   pos;

	// entries ahead of the new one form a prefix of the sorted list
	always_comb begin
		pos = '0;
		for (int i = 0; i < TOP_MAX; i++) begin
			if ((TOP_W'(i) < kept_q) && (score_q[i] >= ins_score)) begin
				pos = pos + TOP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
		end else if (clear) begin
			kept_q <= '0;
		end else if (ins && (pos < k) && (kept_q < k)) begin
			kept_q <= kept_q + TOP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ins && (pos < k)) begin
			for (int i = 0; i < TOP_MAX; i++) begin
				if (TOP_W'(i) == pos) begin
					score_q[i] <= ins_score;
					id_q[i]    <= ins_id;
				end else if ((TOP_W'(i) > pos) && (i > 0)) begin
					score_q[i] <= score_q[i-1];
					id_q[i]    <= id_q[i-1];
				end
			end
		end
	end

	assign kept     = kept_q;
	assign rd_score = score_q[rd_idx[IX_W-1:0]];
	assign rd_id    = id_q[rd_idx[IX_W-1:0]];

endmodule

// ===== design/windowed_topk_dot_product_search.sv =====
// top level: corpus and query loading, window sequencer and result output
//
//  channel | handshake          | words
//  --------+--------------------+-------------------------------------
//  in      | in_valid/in_stall  | func, doc_id, elem_value
//  out     | out_valid/out_stall| score, match_id, rank, last
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// the word that completes a query holds the input while the sequencer skips entries,
// ends the skip, scores each entry of the window on the single multiply-accumulate and
// closes the window, then gives one result per cycle while out_stall is low (none when
// nothing matched).
// reset clears the counters and pointers and loads the config defaults; there is no clearing pass.
// a stalled result holds; the input stays stalled until the last result is taken.
module windowed_topk_dot_product_search #(
	parameter int MAX_DIM      = wtk_pkg::MAX_DIM_DEF,
	parameter int CORPUS_DEPTH = wtk_pkg::CORPUS_DEPTH_DEF,
	parameter int TOP_MAX      = wtk_pkg::TOP_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [31:0]        doc_id,
	input  logic signed [15:0] elem_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [39:0] score,
	output logic [31:0]        match_id,
	output logic [3:0]         rank,
	output logic               last
);

	localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LEN_W = $clog2(MAX_DIM+1);
	localparam int IDX_W = $clog2(CORPUS_DEPTH);
	localparam int CNT_W = $clog2(CORPUS_DEPTH+1);
	localparam int TOP_W = $clog2(TOP_MAX+1);
	localparam int ACC_W = (33 + DIM_W > 41) ? 33 + DIM_W : 41;
	localparam int VEC_DEPTH = CORPUS_DEPTH * (2 ** DIM_W);

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(wtk_pkg::SCORE_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(wtk_pkg::SCORE_MIN);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SK_RD  = 3'd1;
	localparam logic [2:0] S_SK_CHK = 3'd2;
	localparam logic [2:0] S_ID_RD  = 3'd3;
	localparam logic [2:0] S_ID_CHK = 3'd4;
	localparam logic [2:0] S_DOT    = 3'd5;
	localparam logic [2:0] S_INS    = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [31:0]      max_id_diff_q;
	logic [4:0]       top_count_q;
	logic [6:0]       vector_length_q;
	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ws_q;
	logic [CNT_W-1:0] j_q;
	logic [DIM_W-1:0] elem_q;
	logic [LEN_W-1:0] e_q;
	logic [31:0]      qid_q;
	logic [TOP_W-1:0] r_q;

	logic [LEN_W-1:0] len_eff;
	logic [TOP_W-1:0] top_eff;
	logic             in_acc;
	logic             vec_done;
	logic             load_ok;
	logic             query_done;
	logic [31:0]      id_rdata;
	logic [15:0]      vec_rdata;
	logic [15:0]      qry_rdata;
	logic [IDX_W-1:0] id_raddr;
	logic             issue;
	logic signed [32:0] id_gap;
	wtk_pkg::mac_ctl_t mac_ctl;
	logic signed [ACC_W-1:0] acc;
	logic             mac_done;
	logic signed [39:0] sat_score;
	logic [TOP_W-1:0] kept;
	logic signed [39:0] rd_score;
	logic [31:0]      rd_id;

	always_comb begin
		if (vector_length_q == 7'd0) begin
			len_eff = LEN_W'(1);
		end else if (32'(vector_length_q) > 32'(MAX_DIM)) begin
			len_eff = LEN_W'(MAX_DIM);
		end else begin
			len_eff = LEN_W'(vector_length_q);
		end
		if (top_count_q == 5'd0) begin
			top_eff = TOP_W'(1);
		end else if (32'(top_count_q) > 32'(TOP_MAX)) begin
			top_eff = TOP_W'(TOP_MAX);
		end else begin
			top_eff = TOP_W'(top_count_q);
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign vec_done   = (32'(elem_q) + 32'd1 >= 32'(len_eff));
	assign load_ok    = in_acc && (func == wtk_pkg::FUNC_LOAD) && (32'(count_q) < 32'(CORPUS_DEPTH));
	assign query_done = in_acc && (func == wtk_pkg::FUNC_QUERY) && vec_done;
	assign id_gap     = $signed({1'b0, qid_q}) - $signed({1'b0, id_rdata});
	assign issue      = (state_q == S_DOT) && (e_q < len_eff);
	assign id_raddr   = (state_q == S_SK_RD) ? ws_q[IDX_W-1:0] : j_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_id_diff_q   <= wtk_pkg::MAX_ID_DIFF_RST;
			top_count_q     <= wtk_pkg::TOP_COUNT_RST;
			vector_length_q <= wtk_pkg::VECTOR_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wtk_pkg::REG_MAX_ID_DIFF:   max_id_diff_q   <= cfg_data;
				wtk_pkg::REG_TOP_COUNT:     top_count_q     <= cfg_data[4:0];
				wtk_pkg::REG_VECTOR_LENGTH: vector_length_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ws_q    <= '0;
			j_q     <= '0;
			elem_q  <= '0;
			e_q     <= '0;
			r_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (func == wtk_pkg::FUNC_CLEAR) begin
							count_q <= '0;
							ws_q    <= '0;
							elem_q  <= '0;
						end else if (load_ok || (func == wtk_pkg::FUNC_QUERY)) begin
							elem_q <= vec_done ? '0 : elem_q + DIM_W'(1);
							if (load_ok && vec_done) begin
								count_q <= count_q + CNT_W'(1);
							end
							if (query_done) begin
								state_q <= S_SK_RD;
							end
						end
					end
				end
				S_SK_RD: begin
					state_q <= S_SK_CHK;
				end
				S_SK_CHK: begin
					// skip entries too far below the query id, for good
					if ((ws_q < count_q) && (id_gap >= $signed({1'b0, max_id_diff_q}))) begin
						ws_q    <= ws_q + CNT_W'(1);
						state_q <= S_SK_RD;
					end else begin
						j_q     <= ws_q;
						state_q <= S_ID_RD;
					end
				end
				S_ID_RD: begin
					r_q     <= '0;
					state_q <= (j_q < count_q) ? S_ID_CHK : S_OUT;
				end
				S_ID_CHK: begin
					e_q     <= '0;
					state_q <= (id_rdata >= qid_q) ? S_OUT : S_DOT;
				end
				S_DOT: begin
					if (issue) begin
						e_q <= e_q + LEN_W'(1);
					end
					if (mac_done) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					j_q     <= j_q + CNT_W'(1);
					state_q <= S_ID_RD;
				end
				S_OUT: begin
					if (kept == '0) begin
						state_q <= S_IDLE;
					end else if (!out_stall) begin
						r_q <= r_q + TOP_W'(1);
						if (r_q + TOP_W'(1) == kept) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_done) begin
			qid_q <= doc_id;
		end
	end

	wtk_ram #(.WIDTH(16), .DEPTH(VEC_DEPTH)) u_vec_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr ({count_q[IDX_W-1:0], elem_q}),
		.wdata (elem_value),
		.raddr ({j_q[IDX_W-1:0], e_q[DIM_W-1:0]}),
		.rdata (vec_rdata)
	);

	wtk_ram #(.WIDTH(32), .DEPTH(CORPUS_DEPTH)) u_id_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (doc_id),
		.raddr (id_raddr),
		.rdata (id_rdata)
	);

	wtk_ram #(.WIDTH(16), .DEPTH(2 ** DIM_W)) u_qry_ram (
		.clk   (clk),
		.we    (in_acc && (func == wtk_pkg::FUNC_QUERY)),
		.waddr (elem_q),
		.wdata (elem_value),
		.raddr (e_q[DIM_W-1:0]),
		.rdata (qry_rdata)
	);

	logic rd_vld_s1;
	logic rd_last_s1;

	// ram read data arrives in the cycle after the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= issue;
			rd_last_s1 <= issue && (e_q + LEN_W'(1) == len_eff);
		end
	end

	assign mac_ctl.clear = (state_q == S_ID_CHK);
	assign mac_ctl.vld   = rd_vld_s1;
	assign mac_ctl.last  = rd_last_s1;

	wtk_mac #(.ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (qry_rdata),
		.b      (vec_rdata),
		.acc    (acc),
		.done   (mac_done)
	);

	always_comb begin
		if (acc > SAT_HI) begin
			sat_score = 40'(SAT_HI);
		end else if (acc < SAT_LO) begin
			sat_score = 40'(SAT_LO);
		end else begin
			sat_score = 40'(acc);
		end
	end

	wtk_topk #(.TOP_MAX(TOP_MAX)) u_topk (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (query_done),
		.ins       (state_q == S_INS),
		.ins_score (sat_score),
		.ins_id    (id_rdata),
		.k         (top_eff),
		.rd_idx    (r_q),
		.kept      (kept),
		.rd_score  (rd_score),
		.rd_id     (rd_id)
	);

	assign out_valid = (state_q == S_OUT) && (kept != '0);
	assign score     = rd_score;
	assign match_id  = rd_id;
	assign rank      = 4'(r_q);
	assign last      = (r_q + TOP_W'(1) == kept);

`ifndef SYNTH
	a_ws_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ws_q <= count_q) else $error("window start beyond corpus count");
	a_out_rank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (r_q < kept)) else $error("rank beyond kept matches");
	a_mac_in_dot: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == S_DOT)) else $error("mac finished outside scoring");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(r_q)))
		else $error("stalled result moved");
`endif

endmodule
